### rtl/serial_frame_receiver_xor_check_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial frame receiver
// Shared concurrent assertion forms, clocked on rising edge, disabled while active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_XOR_CHECK_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_XOR_CHECK_MACROS_SVH

// same-cycle implication
`define SFRX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sfrx_pkg.sv
// ----------------------------------------------------------------------------
// sfrx_pkg
// Types and constants of the serial frame receiver with XOR check.
// ----------------------------------------------------------------------------
package sfrx_pkg;

    localparam logic [7:0]  XOR_SEED    = 8'hFF;
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    // configuration register indexes
    localparam logic [2:0] CFG_START_BYTE = 3'd0;
    localparam logic [2:0] CFG_ACK_BYTE   = 3'd1;
    localparam logic [2:0] CFG_NAK_BYTE   = 3'd2;
    localparam logic [2:0] CFG_WAIT_TICKS = 3'd3;
    localparam logic [2:0] CFG_EXT_TICKS  = 3'd4;

    // reset values
    localparam logic [7:0]  RST_START_BYTE = 8'd1;
    localparam logic [7:0]  RST_ACK_BYTE   = 8'd6;
    localparam logic [7:0]  RST_NAK_BYTE   = 8'd21;
    localparam logic [15:0] RST_WAIT_TICKS = 16'd1000;
    localparam logic [15:0] RST_EXT_TICKS  = 16'd250;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [2:0] {
        KIND_BYTE     = 3'd0,
        KIND_RESPONSE = 3'd1,
        KIND_CALLBACK = 3'd2,
        KIND_ACK      = 3'd3,
        KIND_NAK      = 3'd4,
        KIND_BAD_SUM  = 3'd5,
        KIND_TIMEOUT  = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_SUM  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  ack_byte;
        logic [7:0]  nak_byte;
        logic [15:0] wait_ticks;
        logic [15:0] extension_ticks;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic [7:0]  byte_index;
        logic [7:0]  command_id;
        logic [7:0]  callback_id;
        logic        send_ack;
        logic        send_nak;
        logic [15:0] naks_seen;
        logic [15:0] bad_frames;
    } t_result;

endpackage

### rtl/sfrx_cfg.sv
// ----------------------------------------------------------------------------
// sfrx_cfg
// Configuration register file, written by index over the config channel.
// ----------------------------------------------------------------------------
module sfrx_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [2:0]    i_index,
    input  logic [15:0]   i_data,
    output sfrx_pkg::t_cfg o_cfg
);

    sfrx_pkg::t_cfg r_cfg;
    sfrx_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                sfrx_pkg::CFG_START_BYTE: n_cfg.start_byte      = i_data[7:0];
                sfrx_pkg::CFG_ACK_BYTE:   n_cfg.ack_byte        = i_data[7:0];
                sfrx_pkg::CFG_NAK_BYTE:   n_cfg.nak_byte        = i_data[7:0];
                sfrx_pkg::CFG_WAIT_TICKS: n_cfg.wait_ticks      = i_data;
                sfrx_pkg::CFG_EXT_TICKS:  n_cfg.extension_ticks = i_data;
                default:                  n_cfg                 = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte      <= sfrx_pkg::RST_START_BYTE;
            r_cfg.ack_byte        <= sfrx_pkg::RST_ACK_BYTE;
            r_cfg.nak_byte        <= sfrx_pkg::RST_NAK_BYTE;
            r_cfg.wait_ticks      <= sfrx_pkg::RST_WAIT_TICKS;
            r_cfg.extension_ticks <= sfrx_pkg::RST_EXT_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/sfrx_core.sv
// ----------------------------------------------------------------------------
// sfrx_core
// Frame phase machine, running XOR, timeout and counters; one word per step.
// ----------------------------------------------------------------------------
module sfrx_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_func,
    input  logic [7:0]        i_rx_byte,
    input  sfrx_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output sfrx_pkg::t_result o_res
);

    sfrx_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_len,   n_len;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_xor,   n_xor;
    logic [7:0]  r_type,  n_type;
    logic [7:0]  r_cmd,   n_cmd;
    logic [7:0]  r_cb,    n_cb;
    logic        r_ext,   n_ext;
    logic [16:0] r_elap,  n_elap;
    logic [15:0] r_naks,  n_naks;
    logic [15:0] r_bad,   n_bad;

    logic [16:0] limit;
    logic [7:0]  count_inc;

    assign limit     = {1'b0, i_cfg.wait_ticks}
                     + (r_ext ? {1'b0, i_cfg.extension_ticks} : 17'd0);
    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_count = r_count;
        n_xor   = r_xor;
        n_type  = r_type;
        n_cmd   = r_cmd;
        n_cb    = r_cb;
        n_ext   = r_ext;
        n_elap  = r_elap;
        n_naks  = r_naks;
        n_bad   = r_bad;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = sfrx_pkg::KIND_BYTE;

        if (i_func == sfrx_pkg::FUNC_TICK) begin
            if (r_elap != sfrx_pkg::ELAPSED_MAX) begin
                n_elap = r_elap + 17'd1;
            end
            if (n_elap >= limit) begin
                // partial frame gets one extension before timing out
                if (r_phase != sfrx_pkg::PH_IDLE && !r_ext) begin
                    n_ext = 1'b1;
                end else begin
                    n_phase     = sfrx_pkg::PH_IDLE;
                    n_elap      = '0;
                    n_ext       = 1'b0;
                    o_res_valid = 1'b1;
                    o_res.kind  = sfrx_pkg::KIND_TIMEOUT;
                end
            end
        end else begin
            unique case (r_phase)
                sfrx_pkg::PH_IDLE: begin
                    if (i_rx_byte == i_cfg.start_byte) begin
                        n_phase = sfrx_pkg::PH_LEN;
                        n_count = '0;
                        n_xor   = sfrx_pkg::XOR_SEED;
                        n_type  = '0;
                        n_cmd   = '0;
                        n_cb    = '0;
                    end else if (i_rx_byte == i_cfg.ack_byte) begin
                        n_phase     = sfrx_pkg::PH_IDLE;
                        n_elap      = '0;
                        n_ext       = 1'b0;
                        o_res_valid = 1'b1;
                        o_res.kind  = sfrx_pkg::KIND_ACK;
                    end else if (i_rx_byte == i_cfg.nak_byte) begin
                        if (r_naks != sfrx_pkg::COUNT_MAX) begin
                            n_naks = r_naks + 16'd1;
                        end
                        n_phase     = sfrx_pkg::PH_IDLE;
                        n_elap      = '0;
                        n_ext       = 1'b0;
                        o_res_valid = 1'b1;
                        o_res.kind  = sfrx_pkg::KIND_NAK;
                    end
                end
                sfrx_pkg::PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_count = 8'd1;
                    // length zero or one goes straight to the checksum
                    n_phase = (i_rx_byte > 8'd1) ? sfrx_pkg::PH_BODY : sfrx_pkg::PH_SUM;
                    o_res_valid      = 1'b1;
                    o_res.byte_value = i_rx_byte;
                end
                sfrx_pkg::PH_BODY: begin
                    n_xor = r_xor ^ i_rx_byte;
                    case (r_count)
                        8'd1:    n_type = i_rx_byte;
                        8'd2:    n_cmd  = i_rx_byte;
                        8'd3:    n_cb   = i_rx_byte;
                        default: n_type = r_type;
                    endcase
                    n_count = count_inc;
                    if (count_inc >= r_len) begin
                        n_phase = sfrx_pkg::PH_SUM;
                    end
                    o_res_valid      = 1'b1;
                    o_res.byte_value = i_rx_byte;
                    o_res.byte_index = r_count;
                end
                sfrx_pkg::PH_SUM: begin
                    o_res_valid = 1'b1;
                    if (i_rx_byte != r_xor) begin
                        // wait keeps running after a bad checksum
                        if (r_bad != sfrx_pkg::COUNT_MAX) begin
                            n_bad = r_bad + 16'd1;
                        end
                        n_phase        = sfrx_pkg::PH_IDLE;
                        o_res.kind     = sfrx_pkg::KIND_BAD_SUM;
                        o_res.send_nak = 1'b1;
                    end else begin
                        n_phase          = sfrx_pkg::PH_IDLE;
                        n_elap           = '0;
                        n_ext            = 1'b0;
                        o_res.send_ack   = 1'b1;
                        o_res.command_id = r_cmd;
                        if (r_type == 8'd0) begin
                            o_res.kind        = sfrx_pkg::KIND_CALLBACK;
                            o_res.callback_id = r_cb;
                        end else begin
                            o_res.kind = sfrx_pkg::KIND_RESPONSE;
                        end
                    end
                end
                default: n_phase = sfrx_pkg::PH_IDLE;
            endcase
        end

        o_res.naks_seen  = n_naks;
        o_res.bad_frames = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfrx_pkg::PH_IDLE;
            r_len   <= '0;
            r_count <= '0;
            r_xor   <= sfrx_pkg::XOR_SEED;
            r_type  <= '0;
            r_cmd   <= '0;
            r_cb    <= '0;
            r_ext   <= 1'b0;
            r_elap  <= '0;
            r_naks  <= '0;
            r_bad   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_count <= n_count;
            r_xor   <= n_xor;
            r_type  <= n_type;
            r_cmd   <= n_cmd;
            r_cb    <= n_cb;
            r_ext   <= n_ext;
            r_elap  <= n_elap;
            r_naks  <= n_naks;
            r_bad   <= n_bad;
        end
    end

endmodule

### rtl/serial_frame_receiver_xor_check.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_xor_check
// SOF / length / XOR checksum frame receiver with ack, nak and tick timeout.
//
//  channel  dir  handshake             payload
//  s        in   i_s_tvalid/o_s_tready tdata rx_byte, tuser func
//  m        out  o_m_tvalid/i_m_tready tdata result fields, tuser kind
//  cfg      in   i_cfg_valid/o_cfg_ready index 3 bits, data 16 bits
//
// One word per cycle while the output is not stalled: input register, one
// step of the phase machine, output register.
// Words that give no result (ticks before timeout, other idle bytes, start byte) leave nothing.
// A stalled output holds the input register; the input register still
// takes a word while the output waits if it is empty.
// Synchronous active-low reset restores register defaults and idle phase.
// ----------------------------------------------------------------------------
`include "serial_frame_receiver_xor_check_macros.svh"

module serial_frame_receiver_xor_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_s_tuser,   // [0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] byte_value, [15:8] byte_index, [23:16] command_id,
    // [31:24] callback_id, [32] send_ack, [33] send_nak,
    // [49:34] naks_seen, [65:50] bad_frames, [71:66] zero
    output logic [71:0] o_m_tdata,
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic              r_in_valid;
    logic              r_in_func;
    logic [7:0]        r_in_byte;
    logic              r_out_valid, n_out_valid;
    sfrx_pkg::t_result r_out;

    logic              s_accept;
    logic              advance;
    logic              res_valid;
    sfrx_pkg::t_result res;
    sfrx_pkg::t_cfg    cfg;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign s_accept    = i_s_tvalid && o_s_tready;

    sfrx_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sfrx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_func      (r_in_func),
        .i_rx_byte   (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_func <= i_s_tuser[0];
            r_in_byte <= i_s_tdata;
        end
    end

    always_comb begin
        if (advance) begin
            n_out_valid = res_valid;
        end else begin
            n_out_valid = r_out_valid && !i_m_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {6'b0, r_out.bad_frames, r_out.naks_seen, r_out.send_nak,
                         r_out.send_ack, r_out.callback_id, r_out.command_id,
                         r_out.byte_index, r_out.byte_value};

    `SFRX_ASSERT_NOW(a_ack_kind, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[32],
        o_m_tuser == sfrx_pkg::KIND_RESPONSE || o_m_tuser == sfrx_pkg::KIND_CALLBACK,
        "send_ack on a word that is no completed frame")
    `SFRX_ASSERT_NOW(a_nak_kind, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[33],
        o_m_tuser == sfrx_pkg::KIND_BAD_SUM, "send_nak on a word without bad checksum")
    `SFRX_ASSERT_NOW(a_cb_only, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser != sfrx_pkg::KIND_CALLBACK,
        o_m_tdata[31:24] == 8'd0, "callback_id set on a non-callback word")
    `SFRX_ASSERT_NEXT(a_in_drain, i_clk, i_rst_n, advance && !s_accept,
        !r_in_valid, "input register not freed after its word was processed")

endmodule
